// ===== src/scp_pkg.sv =====
package scp_pkg;

  // Fixed field widths of the block's ports.
  localparam int ActionW   = 3;
  localparam int IndexW    = 10;
  localparam int ResultW   = 17;
  localparam int KindW     = 2;
  localparam int RowCountW = 11;
  localparam int CfgW      = 17;
  localparam int CfgIdxW   = 1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_ROW_COUNT = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_RECIP     = 1'd1;

  typedef enum logic [ActionW-1:0] {
    ACT_WRITE  = 3'd0,
    ACT_COUNT  = 3'd1,
    ACT_EDGE   = 3'd2,
    ACT_EMPTY  = 3'd3,
    ACT_FINISH = 3'd4,
    ACT_CLEAR  = 3'd5
  } action_e;

  typedef enum logic [KindW-1:0] {
    KIND_ROW      = 2'd0,
    KIND_MEAN     = 2'd1,
    KIND_RANGE    = 2'd2,
    KIND_OVERFLOW = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_COUNT,
    ST_EDGE_MUL,
    ST_EDGE_DONE,
    ST_MEAN,
    ST_CLEAR
  } state_e;

endpackage

// ===== src/scp_ram.sv =====
module scp_ram #(
  parameter int DataW = 17,
  parameter int AddrW = 11
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [2**AddrW];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/scp_mul.sv =====
module scp_mul #(
  parameter int AW = 27,
  parameter int BW = 17
) (
  input  logic            clk_i,
  input  logic [AW-1:0]   a_i,
  input  logic [BW-1:0]   b_i,
  output logic [AW+BW-1:0] p_o
);

  // One registered multiplier, shared by the edge product and the layer mean.
  logic [AW+BW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= (AW+BW)'(a_i) * (AW+BW)'(b_i);
  end

  assign p_o = p_q;

endmodule

// ===== src/sparsity_chain_propagation.sv =====
// Row fill estimator for a chain of square sparse layers, in unsigned fixed
// point with FRAC_BITS fraction bits. An item is taken at a rising edge where
// start is high and busy is low, and busy stays high until the item is done.
// A result, when the item has one, appears on kind_o, row_o and estimate_o
// for exactly one cycle with result_strobe_o high; the receiver cannot stall,
// so it must take every strobed result. write, empty_row, an out-of-range
// index and the unused action codes never raise busy; count reads and then
// updates the store; finish_layer takes the mean from the shared multiplier;
// an edge goes through store read, shared multiplier, then update. clear
// walks the current bank one entry a cycle. After reset the block clears both
// banks, one entry a cycle, and stays busy meanwhile; configuration writes
// are taken during that time and at any idle moment.
module sparsity_chain_propagation #(
  parameter int MAX_ROWS  = 1024,
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Item port.
  input  logic                             start,
  output logic                             busy,
  input  logic [scp_pkg::ActionW-1:0]      action_i,
  input  logic [scp_pkg::IndexW-1:0]       index_i,
  input  logic [scp_pkg::ResultW-1:0]      value_i,
  input  logic                             row_last_i,
  // Configuration write port.
  input  logic                             cfg_we_i,
  input  logic [scp_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [scp_pkg::CfgW-1:0]         cfg_data_i,
  // Result port.
  output logic                             result_strobe_o,
  output logic [scp_pkg::KindW-1:0]        kind_o,
  output logic [scp_pkg::IndexW-1:0]       row_o,
  output logic [scp_pkg::ResultW-1:0]      estimate_o
);

  import scp_pkg::*;

  // Bank address bits; the two banks share one memory, the top address bit
  // selecting the bank.
  localparam int AW   = $clog2(MAX_ROWS);
  // A stored probability never exceeds one, so it needs one integer bit.
  localparam int VW   = FRAC_BITS + 1;
  // Row counter and effective row count width.
  localparam int CntW = $clog2(MAX_ROWS + 1);
  localparam int NW   = (CntW > RowCountW) ? CntW : RowCountW;
  // Sum of up to MAX_ROWS row results, each at most one.
  localparam int SW   = FRAC_BITS + CntW;
  // Shared multiplier operand widths.
  localparam int MA   = SW;
  localparam int MB   = (VW > ResultW) ? VW : ResultW;
  localparam int PW   = MA + MB;
  localparam int CW   = MB + 1;

  localparam logic [VW-1:0] One      = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [NW-1:0] MaxRowsN = NW'(MAX_ROWS);
  localparam logic [AW-1:0] LastAddr = AW'(MAX_ROWS - 1);

  state_e state_q, state_d;

  logic [RowCountW-1:0] row_count_q;
  logic [ResultW-1:0]   recip_q;

  logic          cur_q, cur_d;
  logic [VW-1:0] running_q, running_d;
  logic [NW-1:0] cursor_q, cursor_d;
  logic [SW-1:0] sum_q, sum_d;
  logic [AW:0]   sweep_q, sweep_d;
  logic [AW-1:0] addr_q, addr_d;
  logic          last_q, last_d;

  logic                strobe_q, strobe_d;
  kind_e               kind_q, kind_d;
  logic [IndexW-1:0]   row_q, row_d;
  logic [ResultW-1:0]  est_q, est_d;

  // Memory and multiplier connections.
  logic          ram_we, ram_re;
  logic [AW:0]   ram_waddr, ram_raddr;
  logic [VW-1:0] ram_wdata, ram_rdata;
  logic [MA-1:0] mul_a;
  logic [MB-1:0] mul_b;
  logic [PW-1:0] mul_p;

  action_e       act_in;
  logic          accept;
  logic [NW-1:0] n_eff;
  logic [NW-1:0] idx_n;
  logic [AW-1:0] idx_addr;
  logic          in_range;
  logic          cursor_full;

  assign act_in      = action_e'(action_i);
  assign accept      = start && (state_q == ST_IDLE);
  assign busy        = (state_q != ST_IDLE);
  assign n_eff       = (NW'(row_count_q) < MaxRowsN) ? NW'(row_count_q) : MaxRowsN;
  assign idx_n       = NW'(index_i);
  assign idx_addr    = idx_n[AW-1:0];
  assign in_range    = idx_n < n_eff;
  assign cursor_full = cursor_q >= n_eff;

  scp_ram #(
    .DataW(VW),
    .AddrW(AW + 1)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  scp_mul #(
    .AW(MA),
    .BW(MB)
  ) u_mul (
    .clk_i(clk_i),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (mul_p)
  );

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= RowCountW'(1024);
      recip_q     <= ResultW'(64);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ROW_COUNT: row_count_q <= cfg_data_i[RowCountW-1:0];
        CFG_RECIP:     recip_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (sweep_q == '1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          case (act_in)
            ACT_COUNT:  state_d = in_range ? ST_COUNT : ST_IDLE;
            ACT_EDGE:   state_d = in_range ? ST_EDGE_MUL : ST_IDLE;
            ACT_FINISH: state_d = ST_MEAN;
            ACT_CLEAR:  state_d = ST_CLEAR;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_COUNT:     state_d = ST_IDLE;
      ST_EDGE_MUL:  state_d = ST_EDGE_DONE;
      ST_EDGE_DONE: state_d = ST_IDLE;
      ST_MEAN:      state_d = ST_IDLE;
      ST_CLEAR: begin
        if (sweep_q[AW-1:0] == LastAddr) state_d = ST_IDLE;
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  // Datapath and result control.
  always_comb begin
    logic [MB-1:0] val_ext;
    logic [VW-1:0] wr_sat;
    logic [CW-1:0] cnt_sum;
    logic [VW-1:0] cnt_sat;
    logic [VW-1:0] new_run;
    logic [PW-1:0] mean_full;
    logic [VW-1:0] mean;
    logic          close_en;
    logic [VW-1:0] close_val;

    val_ext   = MB'(value_i);
    wr_sat    = (val_ext > MB'(One)) ? One : VW'(val_ext);
    cnt_sum   = CW'(ram_rdata) + CW'(recip_q);
    cnt_sat   = (cnt_sum > CW'(One)) ? One : VW'(cnt_sum);
    new_run   = VW'(mul_p >> FRAC_BITS);
    mean_full = mul_p >> FRAC_BITS;
    mean      = (mean_full > PW'(One)) ? One : VW'(mean_full);
    close_en  = 1'b0;
    close_val = '0;

    ram_we    = 1'b0;
    ram_waddr = {cur_q, addr_q};
    ram_wdata = '0;
    ram_re    = accept;
    ram_raddr = {cur_q, idx_addr};

    // The multiplier forms the edge product in its own state and the layer
    // mean otherwise, with the mean operands applied on the accept cycle.
    if (state_q == ST_EDGE_MUL) begin
      mul_a = MA'(running_q);
      mul_b = MB'(One - ram_rdata);
    end else begin
      mul_a = sum_q;
      mul_b = MB'(recip_q);
    end

    cur_d     = cur_q;
    running_d = running_q;
    cursor_d  = cursor_q;
    sum_d     = sum_q;
    sweep_d   = sweep_q;
    addr_d    = addr_q;
    last_d    = last_q;
    strobe_d  = 1'b0;
    kind_d    = kind_q;
    row_d     = row_q;
    est_d     = est_q;

    unique case (state_q)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_q;
        sweep_d   = sweep_q + 1'b1;
      end
      ST_IDLE: begin
        if (accept) begin
          addr_d = idx_addr;
          last_d = row_last_i;
          case (act_in) inside
            ACT_WRITE, ACT_COUNT, ACT_EDGE: begin
              if (!in_range) begin
                strobe_d = 1'b1;
                kind_d   = KIND_RANGE;
                row_d    = '0;
                est_d    = '0;
              end else if (act_in == ACT_WRITE) begin
                ram_we    = 1'b1;
                ram_waddr = {cur_q, idx_addr};
                ram_wdata = wr_sat;
              end
            end
            ACT_EMPTY: begin
              close_en  = 1'b1;
              close_val = '0;
            end
            ACT_CLEAR: begin
              sweep_d = '0;
            end
            default: ;
          endcase
        end
      end
      ST_COUNT: begin
        ram_we    = 1'b1;
        ram_wdata = cnt_sat;
      end
      ST_EDGE_MUL: ;
      ST_EDGE_DONE: begin
        if (last_q) begin
          close_en  = 1'b1;
          close_val = One - new_run;
        end else begin
          running_d = new_run;
        end
      end
      ST_MEAN: begin
        strobe_d  = 1'b1;
        kind_d    = KIND_MEAN;
        row_d     = '0;
        est_d     = ResultW'(mean);
        cur_d     = ~cur_q;
        cursor_d  = '0;
        sum_d     = '0;
        running_d = One;
      end
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = {cur_q, sweep_q[AW-1:0]};
        sweep_d   = sweep_q + 1'b1;
      end
      default: ;
    endcase

    // Closing a row: store it in the bank being built, unless the layer
    // already holds N rows, in which case only an overflow is reported.
    if (close_en) begin
      running_d = One;
      strobe_d  = 1'b1;
      if (cursor_full) begin
        kind_d = KIND_OVERFLOW;
        row_d  = '0;
        est_d  = '0;
      end else begin
        ram_we    = 1'b1;
        ram_waddr = {~cur_q, cursor_q[AW-1:0]};
        ram_wdata = close_val;
        sum_d     = sum_q + SW'(close_val);
        cursor_d  = cursor_q + 1'b1;
        kind_d    = KIND_ROW;
        row_d     = IndexW'(cursor_q);
        est_d     = ResultW'(close_val);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_INIT;
      cur_q     <= 1'b0;
      running_q <= One;
      cursor_q  <= '0;
      sum_q     <= '0;
      sweep_q   <= '0;
      strobe_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      cur_q     <= cur_d;
      running_q <= running_d;
      cursor_q  <= cursor_d;
      sum_q     <= sum_d;
      sweep_q   <= sweep_d;
      strobe_q  <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    last_q <= last_d;
    kind_q <= kind_d;
    row_q  <= row_d;
    est_q  <= est_d;
  end

  assign result_strobe_o = strobe_q;
  assign kind_o          = kind_q;
  assign row_o           = row_q;
  assign estimate_o      = est_q;

endmodule

// ===== tb/sparsity_chain_propagation_tb.sv =====
module sparsity_chain_propagation_tb;
  import scp_pkg::*;

  // Block parameters as instantiated, and the fixed-point one.
  localparam int MAX_ROWS  = 1024;
  localparam int FRAC_BITS = 16;
  localparam logic [ResultW-1:0] ONE = 17'h10000;

  // Action codes the block decodes to nothing.
  localparam logic [ActionW-1:0] ACT_SPARE_6 = 3'd6;
  localparam logic [ActionW-1:0] ACT_SPARE_7 = 3'd7;

  // A clear walks the whole bank, so that is the longest silent item.
  localparam int DRAIN_CYCLES = MAX_ROWS + 16;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    kind_e              kind;
    logic [IndexW-1:0]  row;
    logic [ResultW-1:0] estimate;
  } fill_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic [ActionW-1:0]   action_i;
  logic [IndexW-1:0]    index_i;
  logic [ResultW-1:0]   value_i;
  logic                 row_last_i;
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_index_i;
  logic [CfgW-1:0]      cfg_data_i;
  logic                 result_strobe_o;
  logic [KindW-1:0]     kind_o;
  logic [IndexW-1:0]    row_o;
  logic [ResultW-1:0]   estimate_o;

  sparsity_chain_propagation #(
    .MAX_ROWS (MAX_ROWS),
    .FRAC_BITS(FRAC_BITS)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .action_i       (action_i),
    .index_i        (index_i),
    .value_i        (value_i),
    .row_last_i     (row_last_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .result_strobe_o(result_strobe_o),
    .kind_o         (kind_o),
    .row_o          (row_o),
    .estimate_o     (estimate_o)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Fill estimator. This is the expected behavior of the block, kept in step
  // with every item the block accepts. The two banks are indexed by a select
  // bit: fill_bank[cur_sel] is the vector the edges read, the other one
  // receives the rows of the layer being built.
  // ---------------------------------------------------------------------------
  logic [ResultW-1:0]   fill_bank [2][MAX_ROWS];
  logic                 cur_sel;
  logic [ResultW-1:0]   run_prod;
  logic [RowCountW-1:0] row_pos;
  logic [26:0]          fill_sum;
  logic [RowCountW-1:0] rows_cfg;
  logic [CfgW-1:0]      recip_cfg;

  // Results the block still owes, oldest first.
  fill_result_t expected_fills[$];

  int  mismatch_count = 0;
  int  items_sent = 0;
  int  cycle_count = 0;
  bit  gaps_on = 1'b1;

  function automatic int eff_rows();
    return (rows_cfg < MAX_ROWS) ? int'(rows_cfg) : MAX_ROWS;
  endfunction

  task automatic reset_fill_model();
    for (int i = 0; i < MAX_ROWS; i++) begin
      fill_bank[0][i] = '0;
      fill_bank[1][i] = '0;
    end
    cur_sel   = 1'b0;
    run_prod  = ONE;
    row_pos   = '0;
    fill_sum  = '0;
    rows_cfg  = 11'd1024;
    recip_cfg = 17'd64;
  endtask

  // A row ends either on its last edge or on an empty_row. Once the layer
  // already holds N rows, the row is dropped and flagged as an overflow.
  task automatic close_row(input logic [ResultW-1:0] result);
    run_prod = ONE;
    if (row_pos >= eff_rows()) begin
      expected_fills.push_back('{KIND_OVERFLOW, 10'd0, 17'd0});
    end else begin
      fill_bank[~cur_sel][row_pos[IndexW-1:0]] = result;
      fill_sum = fill_sum + result;
      expected_fills.push_back('{KIND_ROW, row_pos[IndexW-1:0], result});
      row_pos = row_pos + 1'b1;
    end
  endtask

  task automatic predict_fill(input logic [ActionW-1:0] act,
                              input logic [IndexW-1:0]  idx,
                              input logic [ResultW-1:0] val,
                              input logic               last);
    logic               in_range;
    logic [ResultW:0]   counted;
    logic [ResultW-1:0] col;
    logic [33:0]        prod;
    logic [63:0]        mean;
    in_range = (idx < eff_rows());
    case (act)
      ACT_WRITE: begin
        if (!in_range) expected_fills.push_back('{KIND_RANGE, 10'd0, 17'd0});
        else fill_bank[cur_sel][idx] = (val > ONE) ? ONE : val;
      end
      ACT_COUNT: begin
        if (!in_range) begin
          expected_fills.push_back('{KIND_RANGE, 10'd0, 17'd0});
        end else begin
          counted = fill_bank[cur_sel][idx] + recip_cfg;
          fill_bank[cur_sel][idx] = (counted > ONE) ? ONE : counted[ResultW-1:0];
        end
      end
      ACT_EDGE: begin
        // An out-of-range column leaves the row open even if it was marked last.
        if (!in_range) begin
          expected_fills.push_back('{KIND_RANGE, 10'd0, 17'd0});
        end else begin
          col = fill_bank[cur_sel][idx];
          if (col > ONE) col = ONE;
          prod = 34'(run_prod) * 34'(ONE - col);
          run_prod = prod[FRAC_BITS +: ResultW];
          if (last) close_row(ONE - run_prod);
        end
      end
      ACT_EMPTY: close_row('0);
      ACT_FINISH: begin
        mean = (64'(fill_sum) * 64'(recip_cfg)) >> FRAC_BITS;
        if (mean > ONE) mean = ONE;
        expected_fills.push_back('{KIND_MEAN, 10'd0, mean[ResultW-1:0]});
        cur_sel  = ~cur_sel;
        row_pos  = '0;
        fill_sum = '0;
        run_prod = ONE;
      end
      ACT_CLEAR: begin
        for (int i = 0; i < MAX_ROWS; i++) fill_bank[cur_sel][i] = '0;
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Result checker. A strobed result is taken at the edge that ends its cycle
  // and compared with the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    fill_result_t want;
    if (rst_ni && result_strobe_o) begin
      if (expected_fills.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected result: kind %0d row %0d estimate %0d",
                   kind_o, row_o, estimate_o);
      end else begin
        want = expected_fills.pop_front();
        if (kind_o !== want.kind || row_o !== want.row || estimate_o !== want.estimate) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display({"mismatch: expected kind %0d row %0d estimate %0d, ",
                      "got kind %0d row %0d estimate %0d"},
                     want.kind, want.row, want.estimate, kind_o, row_o, estimate_o);
        end
      end
    end
  end

  // Watchdog against a hung handshake or a missing result.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_fills.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers.
  // ---------------------------------------------------------------------------

  // Offers one item and holds it until the block takes it. The previous item's
  // start is left high, so back-to-back items keep start up without a dip; a
  // random gap may drop start first.
  task automatic send_item(input logic [ActionW-1:0] act,
                           input logic [IndexW-1:0]  idx,
                           input logic [ResultW-1:0] val,
                           input logic               last);
    if (gaps_on && $urandom_range(99) < 33) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    start      <= 1'b1;
    action_i   <= act;
    index_i    <= idx;
    value_i    <= val;
    row_last_i <= last;
    do @(posedge clk_i); while (busy);
    predict_fill(act, idx, val, last);
    if (act != ACT_SPARE_6 && act != ACT_SPARE_7) items_sent++;
  endtask

  // Waits for every owed result, then long enough for a clear still walking
  // the bank to finish, so the block is surely idle afterwards.
  task automatic wait_idle();
    start <= 1'b0;
    while (expected_fills.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Stops offering items until the block has delivered everything owed.
  task automatic hold_until_results_done();
    start <= 1'b0;
    do @(posedge clk_i); while (expected_fills.size() != 0);
  endtask

  // Writes the row count, then the reciprocal. Only called while idle.
  task automatic set_config(input int rows, input int recip);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_ROW_COUNT;
    cfg_data_i  <= CfgW'(rows);
    @(posedge clk_i);
    rows_cfg     = RowCountW'(rows);
    cfg_index_i <= CFG_RECIP;
    cfg_data_i  <= CfgW'(recip);
    @(posedge clk_i);
    recip_cfg    = CfgW'(recip);
    cfg_we_i    <= 1'b0;
  endtask

  // Probabilities: mostly legal, some exactly one, some above one to
  // exercise the write saturation and reach the top value bits.
  function automatic logic [ResultW-1:0] pick_probability();
    int p;
    p = $urandom_range(99);
    if (p < 15) return ResultW'($urandom_range(131071));
    if (p < 25) return ONE;
    return ResultW'($urandom_range(65536));
  endfunction

  function automatic logic pick_bit();
    return 1'($urandom_range(1));
  endfunction

  // Something that breaks the shape of a layer: an index past N, an action
  // the block ignores, a stray write or count, or an empty_row that cuts a
  // row short and throws away its partial product.
  task automatic send_noise_item();
    int n;
    n = eff_rows();
    case ($urandom_range(5))
      0: begin
        if (n < MAX_ROWS)
          send_item(ACT_EDGE, IndexW'($urandom_range(n, MAX_ROWS - 1)),
                    pick_probability(), pick_bit());
        else
          send_item(ACT_SPARE_6, IndexW'($urandom), pick_probability(), pick_bit());
      end
      1: begin
        if (n < MAX_ROWS)
          send_item(pick_bit() ? ACT_WRITE : ACT_COUNT,
                    IndexW'($urandom_range(n, MAX_ROWS - 1)), pick_probability(), pick_bit());
        else
          send_item(ACT_SPARE_7, IndexW'($urandom), pick_probability(), pick_bit());
      end
      2: send_item(pick_bit() ? ACT_SPARE_6 : ACT_SPARE_7, IndexW'($urandom),
                   pick_probability(), pick_bit());
      3: send_item(ACT_WRITE, IndexW'($urandom_range(n - 1)), pick_probability(), pick_bit());
      4: send_item(ACT_COUNT, IndexW'($urandom_range(n - 1)), pick_probability(), pick_bit());
      default: send_item(ACT_EMPTY, IndexW'($urandom), pick_probability(), pick_bit());
    endcase
  endtask

  // One layer: maybe a clear, seed the current vector, rows of edges, finish.
  // With N of 16 or less it may run up to two rows past N so overflow shows up.
  task automatic run_random_layer(input int noise_pct);
    int n;
    int rows;
    int edges;
    n = eff_rows();
    if ($urandom_range(99) < 8)
      send_item(ACT_CLEAR, IndexW'($urandom), pick_probability(), pick_bit());
    repeat ($urandom_range(1, (n < 8) ? n + 2 : 10)) begin
      send_item(pick_bit() ? ACT_WRITE : ACT_COUNT, IndexW'($urandom_range(n - 1)),
                pick_probability(), pick_bit());
    end
    rows = (n <= 16) ? n + $urandom_range(0, 2) : $urandom_range(1, 10);
    repeat (rows) begin
      if ($urandom_range(99) < 15) begin
        send_item(ACT_EMPTY, IndexW'($urandom), pick_probability(), pick_bit());
      end else begin
        edges = $urandom_range(1, 4);
        for (int e = 1; e <= edges; e++) begin
          if ($urandom_range(99) < noise_pct) send_noise_item();
          send_item(ACT_EDGE, IndexW'($urandom_range(n - 1)), pick_probability(), e == edges);
        end
      end
    end
    send_item(ACT_FINISH, IndexW'($urandom), pick_probability(), pick_bit());
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Reset configuration (N = 1024, 1/N = 64): saturating write and count,
  // a row through columns at both ends of the index range, an empty_row that
  // drops a partial product, the ignored actions, a layer mean, and a clear
  // of the bank that just became current.
  task automatic test_reset_config_basics();
    send_item(ACT_WRITE, 10'd0, 17'h1FFFF, 1'b0);
    send_item(ACT_WRITE, 10'd1023, 17'd0, 1'b1);
    send_item(ACT_WRITE, 10'd5, 17'd32768, 1'b0);
    send_item(ACT_COUNT, 10'd5, 17'd0, 1'b0);
    send_item(ACT_COUNT, 10'd0, 17'd0, 1'b0);
    send_item(ACT_EDGE, 10'd5, 17'd0, 1'b0);
    send_item(ACT_EDGE, 10'd0, 17'd0, 1'b0);
    send_item(ACT_EDGE, 10'd1023, 17'd0, 1'b1);
    send_item(ACT_EDGE, 10'd5, 17'd0, 1'b0);
    send_item(ACT_EMPTY, 10'd0, 17'd0, 1'b0);
    send_item(ACT_SPARE_6, 10'h3FF, 17'h1FFFF, 1'b1);
    send_item(ACT_SPARE_7, 10'd0, 17'd0, 1'b0);
    send_item(ACT_FINISH, 10'd0, 17'd0, 1'b0);
    send_item(ACT_CLEAR, 10'd0, 17'd0, 1'b0);
    send_item(ACT_EDGE, 10'd0, 17'd0, 1'b1);
    send_item(ACT_FINISH, 10'd0, 17'd0, 1'b0);
  endtask

  // Tiny layers: out-of-range indices (an edge marked last among them), rows
  // past N, a mean that saturates at one, and N = 0 where a count is out of
  // range and an empty_row overflows.
  task automatic test_tiny_layers();
    wait_idle();
    set_config(2, 32768);
    send_item(ACT_WRITE, 10'd2, ONE, 1'b0);
    send_item(ACT_EDGE, 10'd2, 17'd0, 1'b1);
    send_item(ACT_WRITE, 10'd1, ONE, 1'b0);
    send_item(ACT_EDGE, 10'd1, 17'd0, 1'b1);
    send_item(ACT_EMPTY, 10'd0, 17'd0, 1'b0);
    send_item(ACT_EMPTY, 10'd0, 17'd0, 1'b0);
    send_item(ACT_FINISH, 10'd0, 17'd0, 1'b0);
    wait_idle();
    set_config(2, 65536);
    send_item(ACT_WRITE, 10'd0, ONE, 1'b0);
    send_item(ACT_WRITE, 10'd1, ONE, 1'b0);
    send_item(ACT_EDGE, 10'd0, 17'd0, 1'b1);
    send_item(ACT_EDGE, 10'd1, 17'd0, 1'b1);
    send_item(ACT_FINISH, 10'd0, 17'd0, 1'b0);
    wait_idle();
    set_config(0, 0);
    send_item(ACT_COUNT, 10'd0, 17'd0, 1'b0);
    send_item(ACT_EMPTY, 10'd0, 17'd0, 1'b0);
    send_item(ACT_FINISH, 10'd0, 17'd0, 1'b0);
  endtask

  // Random layers across a spread of settings, from one row per layer to
  // nearly full size, with a little noise mixed into the rows.
  task automatic test_random_layers();
    int rows_set [6] = '{4, 16, 1, 7, 600, 1023};
    int recip_set [6];
    int goal;
    recip_set = '{16384, 4096, 65536, $urandom_range(1, 65535), $urandom_range(1, 65535), 64};
    foreach (rows_set[i]) begin
      wait_idle();
      set_config(rows_set[i], recip_set[i]);
      goal = items_sent + 110;
      while (items_sent < goal) run_random_layer(10);
    end
  endtask

  // Same kind of traffic with start never dropped between items.
  task automatic test_gapless_burst();
    int goal;
    wait_idle();
    set_config(5, 13107);
    gaps_on = 1'b0;
    goal = items_sent + 150;
    while (items_sent < goal) run_random_layer(10);
    gaps_on = 1'b1;
  endtask

  // The sender stops after each layer until the block has delivered every
  // owed result, then resumes.
  task automatic test_pause_for_results();
    int goal;
    wait_idle();
    set_config(8, 8192);
    goal = items_sent + 100;
    while (items_sent < goal) begin
      run_random_layer(15);
      hold_until_results_done();
    end
  endtask

  // Full-size layers with columns anywhere in the index range.
  task automatic test_full_size_layers();
    int goal;
    wait_idle();
    set_config(1024, 64);
    goal = items_sent + 100;
    while (items_sent < goal) run_random_layer(10);
  endtask

  initial begin
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    action_i    <= '0;
    index_i     <= '0;
    value_i     <= '0;
    row_last_i  <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    reset_fill_model();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    // The block clears both banks after reset; send_item waits on busy.

    test_reset_config_basics();
    test_tiny_layers();
    test_random_layers();
    test_gapless_burst();
    test_pause_for_results();
    test_full_size_layers();

    wait_idle();
    if (mismatch_count == 0 && expected_fills.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatch_count,
               expected_fills.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/scp_pkg.sv
src/scp_ram.sv
src/scp_mul.sv
src/sparsity_chain_propagation.sv
tb/sparsity_chain_propagation_tb.sv
